FILE: design/pol_pkg.sv
package pol_pkg;

    // Field widths fixed by the interface
    localparam int WORD_W   = 32;
    localparam int REQ_W    = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 5;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [STATUS_W-1:0] t_status;

    // Request codes
    localparam t_req REQ_INSERT = 3'd0;
    localparam t_req REQ_DELETE = 3'd1;
    localparam t_req REQ_READ   = 3'd2;
    localparam t_req REQ_FIND   = 3'd3;
    localparam t_req REQ_CLEAR  = 3'd4;

    // Status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_POS   = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // Broadcast from the control to every cell
    typedef struct packed {
        logic  do_insert;
        logic  do_delete;
        t_pos  pos;
        t_word value;
    } t_cell_ctl;

endpackage

FILE: design/pol_cell.sv
module pol_cell #(
    parameter int IDX = 0,
    parameter int XW  = 6,
    parameter int CW  = 6
) (
    input  logic               i_clk,
    input  pol_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_count,
    input  pol_pkg::t_word     i_prev_value,
    input  pol_pkg::t_word     i_next_value,
    output pol_pkg::t_word     o_value,
    output logic               o_sel,
    output logic               o_match
);

    localparam logic [XW-1:0] L_IDX = XW'(IDX);

    pol_pkg::t_word  r_value;
    pol_pkg::t_word  n_value;
    logic [XW-1:0]   pos_x;
    logic [XW-1:0]   count_x;

    assign pos_x   = XW'(i_ctl.pos);
    assign count_x = XW'(i_count);

    // Shift toward the tail on insert, toward the head on delete
    always_comb begin
        n_value = r_value;
        if (i_ctl.do_insert) begin
            if (L_IDX > pos_x) begin
                n_value = i_prev_value;
            end else if (L_IDX == pos_x) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.do_delete) begin
            if (L_IDX >= pos_x) begin
                n_value = i_next_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Report position hit and value match of a live entry
    assign o_value = r_value;
    assign o_sel   = (L_IDX == pos_x);
    assign o_match = (L_IDX < count_x) && (r_value == i_ctl.value);

endmodule

FILE: design/pol_collect.sv
module pol_collect #(
    parameter int CAPACITY = 32,
    parameter int IDXW     = 5
) (
    input  pol_pkg::t_word  i_values [CAPACITY],
    input  logic [CAPACITY-1:0] i_sel,
    input  logic [CAPACITY-1:0] i_match,
    output pol_pkg::t_word  o_read_value,
    output logic            o_found,
    output logic [IDXW-1:0] o_found_idx
);

    logic [CAPACITY-1:0] first_hit;

    // Isolate the lowest matching position
    assign first_hit = i_match & (~i_match + CAPACITY'(1));
    assign o_found   = |i_match;

    // Gather the selected entry and encode the first match
    always_comb begin
        o_read_value = '0;
        o_found_idx  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_read_value = o_read_value | (i_values[i] & {pol_pkg::WORD_W{i_sel[i]}});
            o_found_idx  = o_found_idx | (IDXW'(i) & {IDXW{first_hit[i]}});
        end
    end

endmodule

FILE: design/positional_ordered_list_top.sv
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_req_type, i_position, i_value
// result    out        o_valid / i_ready    o_status, o_read_value, o_found_position,
//                                           o_entry_count
//
// One item is taken per cycle unless the output stalls: every cell shifts, loads or
// compares in the accepting cycle; the result lands in the output register at that edge.
// The row of CAPACITY cells and the match/read gathering across it set that path.
// Reset clears the entry count and the output valid; cell contents are left as they are.
// While a result waits, o_ready stays high only if i_ready takes it in the same cycle.
module positional_ordered_list_top #(
    parameter int CAPACITY = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  pol_pkg::t_req          i_req_type,
    input  pol_pkg::t_pos          i_position,
    input  pol_pkg::t_word         i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output pol_pkg::t_status       o_status,
    output pol_pkg::t_word         o_read_value,
    output logic [pol_pkg::FPOS_W-1:0] o_found_position,
    output pol_pkg::t_pos          o_entry_count
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = pol_pkg::POS_W;
    localparam int FPOS_W = pol_pkg::FPOS_W;
    localparam int XW     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IDXW   = $clog2(CAPACITY);

    logic                    accept;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [XW-1:0]           count_x;
    logic [XW-1:0]           pos_x;
    pol_pkg::t_cell_ctl      ctl;
    pol_pkg::t_word          cell_val [CAPACITY];
    logic [CAPACITY-1:0]     cell_sel;
    logic [CAPACITY-1:0]     cell_match;
    pol_pkg::t_word          gath_value;
    logic                    gath_found;
    logic [IDXW-1:0]         gath_idx;

    logic                    r_valid;
    pol_pkg::t_status        r_status;
    pol_pkg::t_status        n_status;
    pol_pkg::t_word          r_read_value;
    pol_pkg::t_word          n_read_value;
    logic [FPOS_W-1:0]       r_found_position;
    logic [FPOS_W-1:0]       n_found_position;
    pol_pkg::t_pos           r_entry_count;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign count_x = XW'(r_count);
    assign pos_x   = XW'(i_position);

    // Decode the request against the current count
    always_comb begin
        n_count          = r_count;
        n_status         = pol_pkg::ST_OK;
        n_read_value     = '0;
        n_found_position = '0;
        ctl.do_insert    = 1'b0;
        ctl.do_delete    = 1'b0;
        ctl.pos          = i_position;
        ctl.value        = i_value;
        case (i_req_type)
            pol_pkg::REQ_INSERT: begin
                if (pos_x > count_x) begin
                    n_status = pol_pkg::ST_BAD_POS;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = pol_pkg::ST_FULL;
                end else begin
                    ctl.do_insert = accept;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            pol_pkg::REQ_DELETE: begin
                if (pos_x >= count_x) begin
                    n_status = pol_pkg::ST_BAD_POS;
                end else begin
                    ctl.do_delete = accept;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            pol_pkg::REQ_READ: begin
                if (pos_x >= count_x) begin
                    n_status = pol_pkg::ST_BAD_POS;
                end else begin
                    n_read_value = gath_value;
                end
            end
            pol_pkg::REQ_FIND: begin
                if (gath_found) begin
                    n_found_position = FPOS_W'(gath_idx);
                end else begin
                    n_status = pol_pkg::ST_NOT_FOUND;
                end
            end
            pol_pkg::REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Row of cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pol_cell #(
            .IDX (g),
            .XW  (XW),
            .CW  (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_count      (r_count),
            .i_prev_value (cell_val[(g == 0) ? g : g - 1]),
            .i_next_value (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
            .o_value      (cell_val[g]),
            .o_sel        (cell_sel[g]),
            .o_match      (cell_match[g])
        );
    end

    pol_collect #(
        .CAPACITY (CAPACITY),
        .IDXW     (IDXW)
    ) u_collect (
        .i_values     (cell_val),
        .i_sel        (cell_sel),
        .i_match      (cell_match),
        .o_read_value (gath_value),
        .o_found      (gath_found),
        .o_found_idx  (gath_idx)
    );

    // Advance the count on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status         <= n_status;
            r_read_value     <= n_read_value;
            r_found_position <= n_found_position;
            r_entry_count    <= POS_W'(n_count);
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_read_value     = r_read_value;
    assign o_found_position = r_found_position;
    assign o_entry_count    = r_entry_count;

    // Count never runs past the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Clear empties the list
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req_type == pol_pkg::REQ_CLEAR) |=> r_count == '0)
        else $error("clear did not empty the list");

    // Successful insert grows the list by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req_type == pol_pkg::REQ_INSERT) && (n_status == pol_pkg::ST_OK)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list");

    // A miss reports position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == pol_pkg::ST_NOT_FOUND) |-> o_found_position == '0)
        else $error("miss with nonzero position");

    // Read data only comes with an ok status
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_read_value != '0) |-> o_status == pol_pkg::ST_OK)
        else $error("read data with error status");

endmodule
